// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define HLKC_ASSERT(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error(msg);

// checked at every edge, reset included
`define HLKC_ASSERT_ALWAYS(lbl, clk, expr, msg) \
	lbl: assert property (@(posedge clk) expr) else $error(msg);

`endif

// ----- hdl/hlkc_pkg.sv -----
// Types, codes and SHA-256 constants for the HMAC-tagged LRU key cache.
package hlkc_pkg;

	localparam int HDR_WORDS = 10;
	localparam int TAG_WORDS = 4;
	localparam int KEY_WORDS = 8;
	localparam int HDR_BYTES = 80;
	localparam int KEY_BYTES = 32;
	localparam int INNER_BITS = (64 + HDR_BYTES) * 8;
	localparam int OUTER_BITS = (64 + KEY_BYTES) * 8;

	localparam logic [1:0] MODE_LOOKUP = 2'd0;
	localparam logic [1:0] MODE_PUT    = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [1:0] ST_MISS  = 2'd0;
	localparam logic [1:0] ST_HIT   = 2'd1;
	localparam logic [1:0] ST_PUT   = 2'd2;
	localparam logic [1:0] ST_CLEAR = 2'd3;

	typedef enum logic [1:0] {OP_NONE, OP_LOOKUP, OP_PUT, OP_CLEAR} op_t;
	typedef enum logic [1:0] {BUF_HDR, BUF_TAG, BUF_KEY} buf_t;

	typedef struct packed {
		op_t         op;
		logic        wr;
		buf_t        sel;
		logic [3:0]  widx;
		logic [63:0] word;
	} cmd_t;

	typedef enum logic [3:0] {
		B_IDLE, B_FIND, B_KEY, B_HSTART, B_HWAIT, B_HIT, B_HRD, B_HOUT,
		B_MISS, B_EVICT, B_FREE, B_WR, B_PUTOUT, B_CLROUT
	} bst_t;

	typedef enum logic [2:0] {HB_IPAD, HB_HDR0, HB_HDR1, HB_OPAD, HB_DIG} hblk_t;

	localparam logic [255:0] SHA_IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

endpackage

// ----- hdl/hlkc_sha_core.sv -----
// Iterative SHA-256 compression, one round per cycle.
module hlkc_sha_core import hlkc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [255:0] hv_in,
	input  logic [511:0] blk_in,
	output logic         done,
	output logic [255:0] digest
);

	logic [31:0] st_q [8];
	logic [31:0] hv_q [8];
	logic [31:0] w_q [16];
	logic [31:0] dg_q [8];
	logic [5:0]  rnd_q;
	logic        busy_q, fin_q, done_q;

	logic [31:0] t1, t2, w_new;

	always_comb begin
		t1 = st_q[7] + big_sigma1(st_q[4]) + ((st_q[4] & st_q[5]) ^ (~st_q[4] & st_q[6]))
			+ SHA_K[rnd_q] + w_q[0];
		t2 = big_sigma0(st_q[0]) + ((st_q[0] & st_q[1]) ^ (st_q[0] & st_q[2]) ^ (st_q[1] & st_q[2]));
		w_new = w_q[0] + small_sigma0(w_q[1]) + w_q[9] + small_sigma1(w_q[14]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			rnd_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q  <= '0;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					busy_q <= 1'b0;
					fin_q  <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			for (int i = 0; i < 8; i++) begin
				st_q[i] <= hv_in[255 - 32 * i -: 32];
				hv_q[i] <= hv_in[255 - 32 * i -: 32];
			end
			for (int i = 0; i < 16; i++) begin
				w_q[i] <= blk_in[511 - 32 * i -: 32];
			end
		end else if (busy_q) begin
			st_q[0] <= t1 + t2;
			st_q[1] <= st_q[0];
			st_q[2] <= st_q[1];
			st_q[3] <= st_q[2];
			st_q[4] <= st_q[3] + t1;
			st_q[5] <= st_q[4];
			st_q[6] <= st_q[5];
			st_q[7] <= st_q[6];
			for (int i = 0; i < 15; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[15] <= w_new;
		end
		if (fin_q) begin
			for (int i = 0; i < 8; i++) begin
				dg_q[i] <= hv_q[i] + st_q[i];
			end
		end
	end

	assign done = done_q;
	assign digest = {dg_q[0], dg_q[1], dg_q[2], dg_q[3], dg_q[4], dg_q[5], dg_q[6], dg_q[7]};

endmodule

// ----- hdl/hlkc_front.sv -----
// Front end: classifies input words into commands and queues them.
module hlkc_front import hlkc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] word,
	input  logic [3:0]  word_index,
	input  logic        final_word,
	output cmd_t        cmd,
	output logic        cmd_valid,
	input  logic        cmd_pop
);

	cmd_t       c;
	logic       keep, push;
	cmd_t       q_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	always_comb begin
		c.op   = OP_NONE;
		c.wr   = 1'b0;
		c.sel  = BUF_HDR;
		c.widx = word_index;
		c.word = word;
		case (mode)
			MODE_LOOKUP: begin
				c.wr = word_index < 4'(HDR_WORDS + TAG_WORDS);
				if (word_index >= 4'(HDR_WORDS)) begin
					c.sel  = BUF_TAG;
					c.widx = word_index - 4'(HDR_WORDS);
				end
				if (final_word) c.op = OP_LOOKUP;
			end
			MODE_PUT: begin
				c.wr  = word_index < 4'(KEY_WORDS);
				c.sel = BUF_KEY;
				if (final_word) c.op = OP_PUT;
			end
			MODE_CLEAR: begin
				c.op = OP_CLEAR;
			end
			default: ;
		endcase
	end

	// words that neither store nor finish anything are dropped here
	assign keep = c.wr || (c.op != OP_NONE);
	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall && keep;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd = q_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (cmd_pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(cmd_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wp_q] <= c;
	end

endmodule

// ----- hdl/hlkc_back.sv -----
// Back end: key store, LRU bookkeeping, HMAC sequencing and result register.
module hlkc_back import hlkc_pkg::*; #(
	parameter int ENTRIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        cmd_valid,
	output logic        cmd_pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] key_word,
	output logic        last
);

	localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam int AW = SW + 2;
	localparam int MD = ENTRIES * 4;

	bst_t state_q, state_d;

	logic [63:0] cmem [MD];
	logic [63:0] mmem [MD];
	logic [63:0] crd_q, mrd_q;
	logic [AW-1:0] raddr;

	logic [ENTRIES-1:0] valid_q;
	logic [SW-1:0] rec_q [ENTRIES];
	logic [SW-1:0] ins_q [ENTRIES];
	logic [CW-1:0] count_q, r_q;
	logic [SW-1:0] sidx_q, slot_q;
	logic [2:0]    cnt_q;
	hblk_t         blk_q;

	logic [63:0]  hdr_q [HDR_WORDS];
	logic [63:0]  tag_q [TAG_WORDS];
	logic [63:0]  kbuf_q [KEY_WORDS];
	logic [63:0]  kw_q [4];
	logic [255:0] hv_q, inner_q;

	logic        out_valid_q, last_q;
	logic [1:0]  status_q;
	logic [63:0] key_word_q;

	logic         core_start, core_done;
	logic [255:0] core_digest, hv_in, key256;
	logic [511:0] blk;
	logic         free, full, find_hit, evict_hit, tag_ok;
	logic         out_ld, out_lst;
	logic [1:0]   out_st;

	assign raddr = {slot_q, cnt_q[1:0]};
	assign free = !out_valid_q || !out_stall;
	assign full = (count_q == CW'(ENTRIES));
	assign find_hit = (r_q != count_q) && valid_q[sidx_q] && (ins_q[sidx_q] == SW'(r_q));
	assign evict_hit = valid_q[sidx_q] && (rec_q[sidx_q] == SW'(count_q - CW'(1)));
	assign key256 = {kw_q[0], kw_q[1], kw_q[2], kw_q[3]};
	assign tag_ok = (core_digest == {tag_q[0], tag_q[1], tag_q[2], tag_q[3]});
	assign hv_in = (blk_q == HB_IPAD || blk_q == HB_OPAD) ? SHA_IV : hv_q;

	// HMAC: two inner-hash blocks after the ipad block, one outer block after opad
	always_comb begin
		case (blk_q)
			HB_IPAD: blk = {key256 ^ {32{8'h36}}, {32{8'h36}}};
			HB_HDR0: blk = {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3],
				hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]};
			HB_HDR1: blk = {hdr_q[8], hdr_q[9], 32'h80000000, 288'h0, 64'(INNER_BITS)};
			HB_OPAD: blk = {key256 ^ {32{8'h5c}}, {32{8'h5c}}};
			HB_DIG:  blk = {inner_q, 32'h80000000, 160'h0, 64'(OUTER_BITS)};
			default: blk = '0;
		endcase
	end

	hlkc_sha_core u_sha (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (core_start),
		.hv_in  (hv_in),
		.blk_in (blk),
		.done   (core_done),
		.digest (core_digest)
	);

	always_comb begin
		state_d    = state_q;
		cmd_pop    = 1'b0;
		core_start = 1'b0;
		out_ld     = 1'b0;
		out_st     = ST_MISS;
		out_lst    = 1'b1;
		case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					case (cmd.op)
						OP_LOOKUP: state_d = B_FIND;
						OP_PUT:    state_d = full ? B_EVICT : B_FREE;
						OP_CLEAR:  state_d = B_CLROUT;
						default: ;
					endcase
				end
			end
			B_FIND: begin
				if (r_q == count_q) state_d = B_MISS;
				else if (find_hit) state_d = B_KEY;
			end
			B_KEY: begin
				if (cnt_q == 3'd4) state_d = B_HSTART;
			end
			B_HSTART: begin
				core_start = 1'b1;
				state_d = B_HWAIT;
			end
			B_HWAIT: begin
				if (core_done) begin
					if (blk_q == HB_DIG) state_d = tag_ok ? B_HIT : B_FIND;
					else state_d = B_HSTART;
				end
			end
			B_HIT: state_d = B_HRD;
			B_HRD: state_d = B_HOUT;
			B_HOUT: begin
				if (free) begin
					out_ld  = 1'b1;
					out_st  = ST_HIT;
					out_lst = (cnt_q == 3'd3);
					state_d = (cnt_q == 3'd3) ? B_IDLE : B_HRD;
				end
			end
			B_MISS: begin
				if (free) begin
					out_ld  = 1'b1;
					state_d = B_IDLE;
				end
			end
			B_EVICT: begin
				if (evict_hit) state_d = B_FREE;
			end
			B_FREE: begin
				if (!valid_q[sidx_q]) state_d = B_WR;
			end
			B_WR: begin
				if (cnt_q == 3'd3) state_d = B_PUTOUT;
			end
			B_PUTOUT: begin
				if (free) begin
					out_ld  = 1'b1;
					out_st  = ST_PUT;
					state_d = B_IDLE;
				end
			end
			B_CLROUT: begin
				if (free) begin
					out_ld  = 1'b1;
					out_st  = ST_CLEAR;
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
			count_q     <= '0;
			r_q         <= '0;
			sidx_q      <= '0;
			cnt_q       <= '0;
			blk_q       <= HB_IPAD;
			for (int t = 0; t < ENTRIES; t++) begin
				rec_q[t] <= '0;
				ins_q[t] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (out_ld) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						r_q    <= '0;
						sidx_q <= '0;
						if (cmd.op == OP_CLEAR) begin
							valid_q <= '0;
							count_q <= '0;
							for (int t = 0; t < ENTRIES; t++) begin
								rec_q[t] <= '0;
								ins_q[t] <= '0;
							end
						end
					end
				end
				B_FIND: begin
					if (find_hit) cnt_q <= '0;
					else if (r_q != count_q) sidx_q <= sidx_q + SW'(1);
				end
				B_KEY: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd4) blk_q <= HB_IPAD;
				end
				B_HWAIT: begin
					if (core_done) begin
						case (blk_q)
							HB_IPAD: blk_q <= HB_HDR0;
							HB_HDR0: blk_q <= HB_HDR1;
							HB_HDR1: blk_q <= HB_OPAD;
							HB_OPAD: blk_q <= HB_DIG;
							default: begin
								// next entry in insertion order on a tag mismatch
								if (!tag_ok) begin
									r_q    <= r_q + CW'(1);
									sidx_q <= '0;
								end
							end
						endcase
					end
				end
				B_HIT: begin
					for (int t = 0; t < ENTRIES; t++) begin
						if (valid_q[t] && rec_q[t] < rec_q[slot_q]) rec_q[t] <= rec_q[t] + SW'(1);
					end
					rec_q[slot_q] <= '0;
					cnt_q <= '0;
				end
				B_HOUT: begin
					if (free) cnt_q <= cnt_q + 3'd1;
				end
				B_EVICT: begin
					if (evict_hit) begin
						for (int t = 0; t < ENTRIES; t++) begin
							if (valid_q[t] && SW'(t) != sidx_q && ins_q[t] > ins_q[sidx_q])
								ins_q[t] <= ins_q[t] - SW'(1);
						end
						valid_q[sidx_q] <= 1'b0;
						rec_q[sidx_q]   <= '0;
						ins_q[sidx_q]   <= '0;
						count_q         <= count_q - CW'(1);
						sidx_q          <= '0;
					end else begin
						sidx_q <= sidx_q + SW'(1);
					end
				end
				B_FREE: begin
					if (!valid_q[sidx_q]) cnt_q <= '0;
					else sidx_q <= sidx_q + SW'(1);
				end
				B_WR: begin
					cnt_q <= cnt_q + 3'd1;
					if (cnt_q == 3'd3) begin
						for (int t = 0; t < ENTRIES; t++) begin
							if (valid_q[t]) rec_q[t] <= rec_q[t] + SW'(1);
						end
						valid_q[slot_q] <= 1'b1;
						rec_q[slot_q]   <= '0;
						ins_q[slot_q]   <= SW'(count_q);
						count_q         <= count_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop && cmd.wr) begin
			case (cmd.sel)
				BUF_HDR: hdr_q[cmd.widx] <= cmd.word;
				BUF_TAG: tag_q[cmd.widx[1:0]] <= cmd.word;
				BUF_KEY: kbuf_q[cmd.widx[2:0]] <= cmd.word;
				default: ;
			endcase
		end
		if ((state_q == B_FIND && find_hit) || (state_q == B_FREE && !valid_q[sidx_q]))
			slot_q <= sidx_q;
		// read data is registered and arrives in the cycle after its address
		if (state_q == B_KEY && cnt_q != 3'd0) kw_q[cnt_q[1:0] - 2'd1] <= mrd_q;
		if (state_q == B_HWAIT && core_done) begin
			hv_q <= core_digest;
			if (blk_q == HB_HDR1) inner_q <= core_digest;
		end
		if (out_ld) begin
			status_q   <= out_st;
			key_word_q <= (out_st == ST_HIT) ? crd_q : 64'h0;
			last_q     <= out_lst;
		end
	end

	always_ff @(posedge clk) begin
		crd_q <= cmem[raddr];
		mrd_q <= mmem[raddr];
		if (state_q == B_WR) begin
			cmem[raddr] <= kbuf_q[cnt_q[1:0]];
			mmem[raddr] <= kbuf_q[{1'b1, cnt_q[1:0]}];
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign key_word  = key_word_q;
	assign last      = last_q;

endmodule

// ----- hdl/hmac_tagged_lru_key_cache.sv -----
// Top level of the HMAC-tagged LRU session key cache.
// Data words are taken one per cycle while in_stall is low, into a two-deep command queue.
// Lookup: per entry tried, a key read and 5 SHA-256 blocks on one shared round unit,
// after a scan of the slots for that rank; then 4 hit words.
// Put: LRU scan when full, free-slot scan, 4 key-memory writes. Clear: empties the store.
// Reset is asynchronous and empties the queue and the store; key memory is not swept.
module hmac_tagged_lru_key_cache import hlkc_pkg::*; #(
	parameter int ENTRIES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] word,
	input  logic [3:0]  word_index,
	input  logic        final_word,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] key_word,
	output logic        last
);

	cmd_t cmd;
	logic cmd_valid, cmd_pop;

	hlkc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.mode       (mode),
		.word       (word),
		.word_index (word_index),
		.final_word (final_word),
		.cmd        (cmd),
		.cmd_valid  (cmd_valid),
		.cmd_pop    (cmd_pop)
	);

	hlkc_back #(.ENTRIES(ENTRIES)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.key_word  (key_word),
		.last      (last)
	);

endmodule

// ----- hdl/hlkc_checker.sv -----
// Port-level checker for the key cache, bound to the top level.
`include "assert_macros.svh"
module hlkc_checker import hlkc_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [63:0] key_word,
	input logic        last
);

	`HLKC_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !out_valid, "result valid in reset")
	`HLKC_ASSERT(a_hold, clk, arst_n, out_valid && out_stall |=> out_valid && $stable(status) && $stable(key_word) && $stable(last), "stalled result changed")
	`HLKC_ASSERT(a_zero_key, clk, arst_n, out_valid && status != ST_HIT |-> key_word == 64'h0, "key word on non-hit")
	`HLKC_ASSERT(a_single_last, clk, arst_n, out_valid && status != ST_HIT |-> last, "non-hit result not last")

endmodule

bind hmac_tagged_lru_key_cache hlkc_checker u_chk (.*);

// ----- verif/hlkc_checker.sv -----
// Checker for the key cache: predicts results from accepted transactions and compares them.
module hlkc_scoreboard import hlkc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [63:0] word,
	input  logic [3:0]  word_index,
	input  logic        final_word,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  status,
	input  logic [63:0] key_word,
	input  logic        last,
	output int          fail_count,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS = 8;

	typedef struct packed {
		logic [1:0]  st;
		logic [63:0] kw;
		logic        lst;
	} cache_result_t;

	cache_result_t expected_results[$];

	logic [255:0] cipher_keys [SLOTS];
	logic [255:0] mac_keys [SLOTS];
	bit           slot_valid [SLOTS];
	logic [2:0]   recency [SLOTS];
	logic [2:0]   age [SLOTS];
	int           slot_count;
	logic [63:0]  hdr_words [HDR_WORDS];
	logic [63:0]  tag_words [TAG_WORDS];
	logic [63:0]  key_in [KEY_WORDS];

	initial begin
		fail_count = 0;
		pending = 0;
	end

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [255:0] sha_block(input logic [255:0] hin, input logic [511:0] blk);
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		logic [255:0] r;
		for (int i = 0; i < 16; i++)
			w[i] = blk[511 - 32 * i -: 32];
		for (int i = 16; i < 64; i++) begin
			s0 = ror32(w[i - 15], 7) ^ ror32(w[i - 15], 18) ^ (w[i - 15] >> 3);
			s1 = ror32(w[i - 2], 17) ^ ror32(w[i - 2], 19) ^ (w[i - 2] >> 10);
			w[i] = w[i - 16] + s0 + w[i - 7] + s1;
		end
		{a, b, c, d, e, f, g, h} = hin;
		for (int i = 0; i < 64; i++) begin
			t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
				+ SHA_K[i] + w[i];
			t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
		end
		r = {a, b, c, d, e, f, g, h};
		for (int j = 0; j < 8; j++)
			r[255 - 32 * j -: 32] = r[255 - 32 * j -: 32] + hin[255 - 32 * j -: 32];
		return r;
	endfunction

	// message is left-aligned in m, len bytes long (at most 144)
	function automatic logic [255:0] sha256_msg(input logic [1151:0] m, input int len);
		logic [1535:0] padded;
		logic [255:0] hv;
		int total;
		padded = '0;
		padded[1535 -: 1152] = m;
		padded[1535 - 8 * len -: 8] = 8'h80;
		total = ((len + 72) / 64) * 64;
		padded[1535 - 8 * (total - 8) -: 64] = 64'(len * 8);
		hv = SHA_IV;
		for (int i = 0; i < total / 64; i++)
			hv = sha_block(hv, padded[1535 - 512 * i -: 512]);
		return hv;
	endfunction

	function automatic logic [255:0] hmac_sha256(input logic [255:0] mkey, input logic [639:0] hdr);
		logic [255:0] inner_dig;
		inner_dig = sha256_msg({mkey ^ {32{8'h36}}, {32{8'h36}}, hdr}, 144);
		return sha256_msg({mkey ^ {32{8'h5c}}, {32{8'h5c}}, inner_dig, 384'b0}, 96);
	endfunction

	task automatic report(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		fail_count++;
	endtask

	task automatic expect_item(input logic [1:0] st, input logic [63:0] kw, input logic lst);
		cache_result_t r;
		r.st = st;
		r.kw = kw;
		r.lst = lst;
		expected_results.insert(expected_results.size(), r);
	endtask

	task automatic erase_slot(input int s);
		cipher_keys[s] = '0;
		mac_keys[s] = '0;
		slot_valid[s] = 0;
		recency[s] = '0;
		age[s] = '0;
	endtask

	task automatic wipe_store();
		for (int s = 0; s < SLOTS; s++)
			erase_slot(s);
		slot_count = 0;
	endtask

	task automatic store_put();
		int v;
		if (slot_count >= SLOTS) begin
			v = 0;
			for (int s = 0; s < SLOTS; s++)
				if (slot_valid[s] && recency[s] == 3'(slot_count - 1))
					v = s;
			for (int s = 0; s < SLOTS; s++)
				if (slot_valid[s] && s != v && age[s] > age[v])
					age[s]--;
			erase_slot(v);
			slot_count--;
		end
		v = 0;
		for (int s = SLOTS - 1; s >= 0; s--)
			if (!slot_valid[s])
				v = s;
		for (int s = 0; s < SLOTS; s++)
			if (slot_valid[s])
				recency[s]++;
		cipher_keys[v] = {key_in[0], key_in[1], key_in[2], key_in[3]};
		mac_keys[v] = {key_in[4], key_in[5], key_in[6], key_in[7]};
		slot_valid[v] = 1;
		recency[v] = '0;
		age[v] = 3'(slot_count);
		slot_count++;
	endtask

	// first valid slot in insertion order whose MAC matches the tag wins
	task automatic run_lookup();
		int hit;
		logic [639:0] hv;
		logic [255:0] tv;
		hit = -1;
		for (int i = 0; i < HDR_WORDS; i++)
			hv[639 - 64 * i -: 64] = hdr_words[i];
		tv = {tag_words[0], tag_words[1], tag_words[2], tag_words[3]};
		for (int r = 0; r < slot_count; r++)
			for (int s = 0; s < SLOTS; s++)
				if (hit < 0 && slot_valid[s] && age[s] == 3'(r) && hmac_sha256(mac_keys[s], hv) == tv)
					hit = s;
		if (hit < 0) begin
			expect_item(ST_MISS, 64'd0, 1'b1);
		end else begin
			for (int t = 0; t < SLOTS; t++)
				if (slot_valid[t] && recency[t] < recency[hit])
					recency[t]++;
			recency[hit] = '0;
			for (int k = 0; k < 4; k++)
				expect_item(ST_HIT, cipher_keys[hit][255 - 64 * k -: 64], k == 3);
		end
	endtask

	task automatic apply_item();
		case (mode)
			MODE_LOOKUP: begin
				if (word_index < HDR_WORDS)
					hdr_words[word_index] = word;
				else if (word_index < HDR_WORDS + TAG_WORDS)
					tag_words[word_index - HDR_WORDS] = word;
				if (final_word)
					run_lookup();
			end
			MODE_PUT: begin
				if (word_index < KEY_WORDS)
					key_in[word_index] = word;
				if (final_word) begin
					store_put();
					expect_item(ST_PUT, 64'd0, 1'b1);
				end
			end
			MODE_CLEAR: begin
				wipe_store();
				expect_item(ST_CLEAR, 64'd0, 1'b1);
			end
			default: ;
		endcase
	endtask

	task automatic check_result();
		cache_result_t exp_r;
		if (expected_results.size() == 0) begin
			report($sformatf("unexpected result status=%0d key_word=%h", status, key_word));
		end else begin
			exp_r = expected_results.pop_front();
			if (status !== exp_r.st)
				report($sformatf("status %0d, expected %0d", status, exp_r.st));
			if (key_word !== exp_r.kw)
				report($sformatf("key_word %h, expected %h", key_word, exp_r.kw));
			if (last !== exp_r.lst)
				report($sformatf("last %0b, expected %0b", last, exp_r.lst));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_store();
			expected_results.delete();
			for (int i = 0; i < HDR_WORDS; i++)
				hdr_words[i] = '0;
			for (int i = 0; i < TAG_WORDS; i++)
				tag_words[i] = '0;
			for (int i = 0; i < KEY_WORDS; i++)
				key_in[i] = '0;
		end else begin
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				apply_item();
		end
		pending = expected_results.size();
	end

endmodule

// ----- verif/testbench.sv -----
// Top of the key cache testbench: clock, reset, stimulus, output stalls and verdict.
module testbench import hlkc_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [63:0] word;
	logic [3:0]  word_index;
	logic        final_word;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [63:0] key_word;
	logic        last;
	int          fail_count;
	int          pending;

	int          cycle_count;
	int          items_sent;
	int          results_seen;
	bit          calm;
	logic [63:0] hdr_mirror [HDR_WORDS];
	logic [63:0] key_mirror [KEY_WORDS];
	bit          hdr_seen [HDR_WORDS];
	bit          key_seen [KEY_WORDS];
	logic [255:0] mac_pool [$];

	hmac_tagged_lru_key_cache u_top (.*);

	hlkc_scoreboard u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		in_valid = 0;
		mode = MODE_LOOKUP;
		word = '0;
		word_index = '0;
		final_word = 0;
		out_stall = 0;
		cycle_count = 0;
		items_sent = 0;
		results_seen = 0;
		calm = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver: random stall per result, one long hold-off to back the block up
	initial begin
		int n;
		bit quiet;
		@(posedge arst_n);
		forever begin
			if (results_seen % 8 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			n = quiet ? 0 : $urandom_range(0, 10);
			if (results_seen == 6)
				n = 3000;
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 0;
			do @(posedge clk); while (!(out_valid && !out_stall));
			results_seen++;
		end
	end

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic push_word(input logic [1:0] m, input logic [63:0] w, input logic [3:0] idx,
			input logic fin);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		mode <= m;
		word <= w;
		word_index <= idx;
		final_word <= fin;
		in_valid <= 1;
		do @(posedge clk); while (in_stall);
		items_sent++;
		if (m == MODE_LOOKUP && idx < HDR_WORDS) begin
			hdr_mirror[idx] = w;
			hdr_seen[idx] = 1;
		end
		if (m == MODE_PUT && idx < KEY_WORDS) begin
			key_mirror[idx] = w;
			key_seen[idx] = 1;
		end
	endtask

	// tag words with final on the last one, or closed by an out-of-range word
	task automatic send_tag(input logic [255:0] tag);
		bit odd_close;
		odd_close = ($urandom_range(0, 7) == 0);
		for (int i = 0; i < TAG_WORDS; i++)
			push_word(MODE_LOOKUP, tag[255 - 64 * i -: 64], 4'(HDR_WORDS + i),
				!odd_close && i == TAG_WORDS - 1);
		if (odd_close)
			push_word(MODE_LOOKUP, rand64(), 4'($urandom_range(14, 15)), 1);
	endtask

	function automatic logic [639:0] header_now();
		logic [639:0] hv;
		for (int i = 0; i < HDR_WORDS; i++)
			hv[639 - 64 * i -: 64] = hdr_mirror[i];
		return hv;
	endfunction

	task automatic send_lookup(input bit want_hit);
		logic [255:0] tag;
		for (int i = 0; i < HDR_WORDS; i++)
			if (!hdr_seen[i] || $urandom_range(0, 5) != 0)
				push_word(MODE_LOOKUP, rand64(), 4'(i), 0);
		if ($urandom_range(0, 5) == 0)
			push_word(MODE_LOOKUP, rand64(), 4'($urandom_range(14, 15)), 0);
		if (want_hit && mac_pool.size() > 0)
			tag = u_chk.hmac_sha256(mac_pool[$urandom_range(0, mac_pool.size() - 1)],
				header_now());
		else
			tag = {rand64(), rand64(), rand64(), rand64()};
		send_tag(tag);
	endtask

	task automatic send_put();
		bit dup;
		logic [255:0] old_mac;
		logic [255:0] new_mac;
		dup = mac_pool.size() > 0 && $urandom_range(0, 3) == 0;
		if (dup)
			old_mac = mac_pool[$urandom_range(0, mac_pool.size() - 1)];
		for (int i = 0; i < KEY_WORDS; i++)
			if (!key_seen[i] || $urandom_range(0, 5) != 0 || (dup && i >= 4))
				push_word(MODE_PUT, (dup && i >= 4) ? old_mac[255 - 64 * (i - 4) -: 64] : rand64(),
					4'(i), 0);
		if ($urandom_range(0, 2) == 0)
			push_word(MODE_PUT, rand64(), 4'($urandom_range(8, 15)), 1);
		else
			push_word(MODE_PUT, key_mirror[7], 4'd7, 1);
		new_mac = {key_mirror[4], key_mirror[5], key_mirror[6], key_mirror[7]};
		mac_pool.insert(mac_pool.size(), new_mac);
		if (mac_pool.size() > 12)
			void'(mac_pool.pop_front());
	endtask

	initial begin
		int pick;
		for (int i = 0; i < HDR_WORDS; i++)
			hdr_seen[i] = 0;
		for (int i = 0; i < KEY_WORDS; i++)
			key_seen[i] = 0;
		@(posedge arst_n);
		@(posedge clk);

		// directed: lookup on an empty store, extreme words
		for (int i = 0; i < HDR_WORDS + TAG_WORDS; i++)
			push_word(MODE_LOOKUP, (i % 2) ? 64'd0 : '1, 4'(i), i == HDR_WORDS + TAG_WORDS - 1);
		// all-ones cipher key under an all-zero MAC key
		for (int i = 0; i < KEY_WORDS; i++)
			push_word(MODE_PUT, (i < 4) ? '1 : 64'd0, 4'(i), i == KEY_WORDS - 1);
		mac_pool.insert(mac_pool.size(), 256'h0);
		// matching tag gives a hit
		send_tag(u_chk.hmac_sha256('0, header_now()));
		// clear with arbitrary fields, the unused mode, then a lookup on the cleared store
		push_word(MODE_CLEAR, rand64(), 4'd15, 0);
		push_word(MODE_UNUSED, rand64(), 4'($urandom_range(0, 15)), 1);
		push_word(MODE_LOOKUP, rand64(), 4'd13, 1);

		while (items_sent < 300) begin
			calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 19);
			if (pick < 8)
				send_lookup($urandom_range(0, 2) != 0);
			else if (pick < 15)
				send_put();
			else if (pick == 15)
				push_word(MODE_CLEAR, rand64(), 4'($urandom_range(0, 15)), 1'($urandom));
			else if (pick == 16)
				push_word(MODE_UNUSED, rand64(), 4'($urandom_range(0, 15)), 1'($urandom));
			else
				push_word(2'($urandom_range(0, 1)), rand64(), 4'($urandom_range(0, 15)), 0);
		end
		in_valid <= 0;

		do @(posedge clk); while (pending != 0);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
